// ===== src/fqp_pkg.sv =====
package fqp_pkg;

    localparam int NAME_DEPTH = 32;
    localparam int NAME_CAP   = NAME_DEPTH - 1;
    localparam int IDX_W      = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
    localparam int LEN_W      = $clog2(NAME_DEPTH + 1);

    localparam logic [7:0] CH_PLUS        = 8'h2B;
    localparam logic [7:0] CH_SPACE       = 8'h20;
    localparam logic [7:0] CH_PCT         = 8'h25;
    localparam logic [7:0] CH_EQ          = 8'h3D;
    localparam logic [7:0] CH_AMP         = 8'h26;
    localparam logic [7:0] CH_QM          = 8'h3F;
    localparam logic [7:0] CH_BSL         = 8'h5C;
    localparam logic [7:0] CH_NUL         = 8'h00;
    localparam logic [7:0] CH_UPPER_A     = 8'h41;
    localparam logic [7:0] CH_DIGIT_0     = 8'h30;
    localparam logic [7:0] HEX_CASE_MASK  = 8'hDF;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [1:0] VLEN_ONE = 2'd1;
    localparam logic [1:0] VLEN_TWO = 2'd2;
    localparam logic [1:0] VLEN_SAT = 2'd3;

    // Per-query parser state (the name bytes themselves live in the name memory)
    typedef struct packed {
        logic             phase;      // 0 name stage, 1 value stage
        logic [1:0]       esc_step;
        logic [3:0]       esc_high;
        logic [LEN_W-1:0] name_len;
        logic [1:0]       vlen;       // value length, saturating
        logic             held_bsl;
        logic             ovf;
        logic             ended;
        logic             last_bsl;   // last stored name byte is a backslash
    } t_state;

    // Results one request causes, in emission order:
    // name replay, held backslash, single byte, tail backslash, end marker
    typedef struct packed {
        logic [LEN_W-1:0] rep_n;
        logic [1:0]       rep_kind;
        logic             hbsl;
        logic             val;
        logic [7:0]       val_byte;
        logic [1:0]       val_kind;
        logic             tbsl;
        logic             end_mark;
        logic             trunc;
    } t_plan;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } t_wr;

    function automatic logic [7:0] hex_val(input logic [7:0] c);
        if (c >= CH_UPPER_A) begin
            return (c & HEX_CASE_MASK) - CH_UPPER_A + HEX_ALPHA_BASE;
        end else begin
            return c - CH_DIGIT_0;
        end
    endfunction

endpackage

// ===== src/fqp_step.sv =====
module fqp_step import fqp_pkg::*; (
    input  logic       i_mode,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  t_state     i_state,
    output t_state     o_state,
    output t_plan      o_plan,
    output t_wr        o_wr
);

    t_state           s;
    t_plan            plan;
    t_wr              wr;
    logic [7:0]       ch;
    logic [7:0]       hv;
    logic             do_dec;
    logic             dec_valid;
    logic [7:0]       dec_byte;
    logic             act_name;
    logic             act_value;
    logic             act_end;
    logic             act_end_open;
    logic             act_clear;
    logic [7:0]       act_byte;
    logic             entry_open;
    logic             do_end;
    logic [LEN_W-1:0] rep_len;

    always_comb begin
        s            = i_state;
        plan         = '0;
        wr           = '0;
        dec_valid    = 1'b0;
        dec_byte     = CH_NUL;
        act_name     = 1'b0;
        act_value    = 1'b0;
        act_end      = 1'b0;
        act_end_open = 1'b0;
        act_clear    = 1'b0;
        act_byte     = CH_NUL;
        rep_len      = '0;

        ch = (i_data_byte == CH_PLUS) ? CH_SPACE : i_data_byte;
        hv = hex_val(ch);

        // GET decodes every live byte; POST decodes only value bytes
        if (!i_mode) begin
            do_dec = !s.ended && (i_data_byte != CH_NUL);
        end else begin
            do_dec = (i_data_byte != CH_AMP) && !s.ended && (i_data_byte != CH_NUL) && s.phase;
        end

        if (do_dec) begin
            case (s.esc_step)
                ESC_HIGH: begin
                    s.esc_high = hv[3:0];
                    s.esc_step = ESC_LOW;
                end
                ESC_LOW: begin
                    s.esc_step = ESC_NONE;
                    dec_byte   = {s.esc_high, 4'h0} + hv;
                    dec_valid  = 1'b1;
                end
                default: begin
                    if (ch == CH_PCT) begin
                        s.esc_step = ESC_HIGH;
                    end else begin
                        dec_byte  = ch;
                        dec_valid = 1'b1;
                    end
                end
            endcase
        end

        if (!i_mode) begin
            if (!s.ended) begin
                if (i_data_byte == CH_NUL || (dec_valid && dec_byte == CH_NUL)) begin
                    act_end_open = 1'b1;
                    s.ended      = 1'b1;
                end else if (dec_valid) begin
                    if (!s.phase) begin
                        if (dec_byte == CH_EQ) begin
                            s.phase = 1'b1;
                        end else if (dec_byte == CH_AMP || dec_byte == CH_QM) begin
                            act_end = 1'b1;
                        end else begin
                            act_name = 1'b1;
                            act_byte = dec_byte;
                        end
                    end else begin
                        if (dec_byte == CH_AMP) begin
                            act_end = 1'b1;
                        end else begin
                            act_value = 1'b1;
                            act_byte  = dec_byte;
                        end
                    end
                end
            end
        end else begin
            if (i_data_byte == CH_AMP) begin
                act_end   = !s.ended;
                act_clear = 1'b1;
                s.ended   = 1'b0;
            end else if (!s.ended) begin
                if (i_data_byte == CH_NUL) begin
                    act_end = 1'b1;
                    s.ended = 1'b1;
                end else if (!s.phase) begin
                    if (i_data_byte == CH_EQ) begin
                        s.phase = 1'b1;
                    end else begin
                        act_name = 1'b1;
                        act_byte = i_data_byte;
                    end
                end else if (dec_valid) begin
                    if (dec_byte == CH_NUL) begin
                        act_end = 1'b1;
                        s.ended = 1'b1;
                    end else begin
                        act_value = 1'b1;
                        act_byte  = dec_byte;
                    end
                end
            end
        end

        // Store a name byte; POST also passes it straight out
        if (act_name) begin
            if (s.name_len < LEN_W'(NAME_CAP)) begin
                wr.en      = 1'b1;
                wr.addr    = s.name_len[IDX_W-1:0];
                wr.data    = act_byte;
                s.name_len = s.name_len + LEN_W'(1);
                s.last_bsl = (act_byte == CH_BSL);
                if (i_mode) begin
                    plan.val      = 1'b1;
                    plan.val_byte = act_byte;
                    plan.val_kind = KIND_NAME;
                end
            end else begin
                s.ovf = 1'b1;
            end
        end

        // First GET value byte releases the buffered name
        if (act_value) begin
            if (!i_mode && s.vlen == '0) begin
                plan.rep_n    = s.name_len;
                plan.rep_kind = KIND_NAME;
            end
            if (s.held_bsl) begin
                plan.hbsl  = 1'b1;
                s.held_bsl = 1'b0;
            end
            if (act_byte == CH_BSL) begin
                s.held_bsl = 1'b1;
            end else begin
                plan.val      = 1'b1;
                plan.val_byte = act_byte;
                plan.val_kind = KIND_VALUE;
            end
            if (s.vlen != VLEN_SAT) begin
                s.vlen = s.vlen + VLEN_ONE;
            end
        end

        entry_open = s.phase || (s.name_len != '0) || s.ovf;
        do_end     = act_end || (act_end_open && entry_open)
                     || (i_last_byte && !s.ended && entry_open);

        if (do_end) begin
            if (s.vlen == '0) begin
                if (!i_mode) begin
                    // Empty value: name text is the value, trailing backslash cut if 2+ bytes
                    rep_len = s.name_len;
                    if (rep_len >= LEN_W'(2) && s.last_bsl) begin
                        rep_len = rep_len - LEN_W'(1);
                    end
                    plan.rep_n    = rep_len;
                    plan.rep_kind = KIND_VALUE;
                end
            end else if (s.held_bsl && s.vlen < VLEN_TWO) begin
                plan.tbsl = 1'b1;
            end
            plan.end_mark = 1'b1;
            plan.trunc    = s.ovf;
        end

        if (do_end || act_end_open || act_clear || i_last_byte) begin
            s.phase    = 1'b0;
            s.esc_step = ESC_NONE;
            s.esc_high = '0;
            s.name_len = '0;
            s.vlen     = '0;
            s.held_bsl = 1'b0;
            s.ovf      = 1'b0;
        end

        if (i_last_byte) begin
            s.ended = 1'b0;
        end
    end

    assign o_state = s;
    assign o_plan  = plan;
    assign o_wr    = wr;

endmodule

// ===== src/form_query_parser_unit.sv =====
// Form-urlencoded query parser. Raw query bytes enter on the request channel
// (i_in_valid / o_in_stall), one per request, with i_last_byte on the final byte;
// decoded name bytes, value bytes and end-of-entry markers leave on the result
// channel (o_out_valid / i_out_stall), with o_last_result on the final result of
// each request. i_cfg_method_mode selects GET (0) or POST (1) handling and may be
// written only while the block is idle. A request causes 0 to NAME_DEPTH+1
// results. While the result channel does not stall, a request with at most one
// result flows at one per cycle; a request with more results, such as a name
// replay, which reads the name memory one entry per cycle, holds the next request
// off until the last result of the current one has been issued. Results then
// pass a one-entry read stage and an output register, so the result channel
// may stall without losing data. The name memory needs no clearing after reset.
module form_query_parser_unit import fqp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_method_mode,

    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,

    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_name_truncated,
    output logic       o_last_result
);

    // Configuration and parser state
    logic             r_mode;
    t_state           r_state;
    t_state           n_state;
    t_plan            step_plan;
    t_wr              step_wr;

    // Name memory: at most one write per request, one replay read per cycle while the read stage is free
    logic [7:0]       r_name_mem [NAME_DEPTH];
    logic [7:0]       r_rd_data;

    // Result sequencer
    t_plan            r_plan;
    t_plan            n_plan;
    logic [IDX_W-1:0] r_rep_idx;
    logic [IDX_W-1:0] n_rep_idx;
    logic             busy;
    logic             gen_go;
    logic             e_mem;
    logic [7:0]       e_byte;
    logic [1:0]       e_kind;
    logic             e_trunc;
    logic             e_last;

    // Read stage and output register
    logic             r_s1_valid;
    logic             r_s1_mem;
    logic [7:0]       r_s1_byte;
    logic [1:0]       r_s1_kind;
    logic             r_s1_trunc;
    logic             r_s1_last;
    logic             s1_move;
    logic             s1_free;
    logic             out_taken;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [1:0]       r_out_kind;
    logic             r_out_trunc;
    logic             r_out_last;

    logic             in_acc;

    fqp_step u_step (
        .i_mode      (r_mode),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_plan      (step_plan),
        .o_wr        (step_wr)
    );

    // Accept a new request once the current one issues its final result
    assign out_taken  = r_out_valid && !i_out_stall;
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_free    = !r_s1_valid || s1_move;
    assign busy       = (r_plan.rep_n != '0) || r_plan.hbsl || r_plan.val
                        || r_plan.tbsl || r_plan.end_mark;
    assign gen_go     = busy && s1_free;
    assign o_in_stall = busy && !(gen_go && e_last);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_method_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Pick the next pending result, in order: replay, held backslash, byte,
    // tail backslash, end marker
    always_comb begin
        n_plan    = r_plan;
        n_rep_idx = r_rep_idx;
        e_mem     = 1'b0;
        e_byte    = CH_NUL;
        e_kind    = KIND_END;
        e_trunc   = 1'b0;
        e_last    = 1'b0;
        if (r_plan.rep_n != '0) begin
            e_mem        = 1'b1;
            e_kind       = r_plan.rep_kind;
            e_last       = (r_plan.rep_n == LEN_W'(1))
                           && !(r_plan.hbsl || r_plan.val || r_plan.tbsl || r_plan.end_mark);
            n_plan.rep_n = r_plan.rep_n - LEN_W'(1);
            n_rep_idx    = r_rep_idx + IDX_W'(1);
        end else if (r_plan.hbsl) begin
            e_byte      = CH_BSL;
            e_kind      = KIND_VALUE;
            e_last      = !(r_plan.val || r_plan.tbsl || r_plan.end_mark);
            n_plan.hbsl = 1'b0;
        end else if (r_plan.val) begin
            e_byte     = r_plan.val_byte;
            e_kind     = r_plan.val_kind;
            e_last     = !(r_plan.tbsl || r_plan.end_mark);
            n_plan.val = 1'b0;
        end else if (r_plan.tbsl) begin
            e_byte      = CH_BSL;
            e_kind      = KIND_VALUE;
            e_last      = !r_plan.end_mark;
            n_plan.tbsl = 1'b0;
        end else if (r_plan.end_mark) begin
            e_kind          = KIND_END;
            e_trunc         = r_plan.trunc;
            e_last          = 1'b1;
            n_plan.end_mark = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan    <= '0;
            r_rep_idx <= '0;
        end else if (in_acc) begin
            r_plan    <= step_plan;
            r_rep_idx <= '0;
        end else if (gen_go) begin
            r_plan    <= n_plan;
            r_rep_idx <= n_rep_idx;
        end
    end

    // Write the new name byte on accept; read-before-write covers a replay
    // finishing on the same edge
    always_ff @(posedge i_clk) begin
        if (in_acc && step_wr.en) begin
            r_name_mem[step_wr.addr] <= step_wr.data;
        end
        if (gen_go && e_mem) begin
            r_rd_data <= r_name_mem[r_rep_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (gen_go) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_go) begin
            r_s1_mem   <= e_mem;
            r_s1_byte  <= e_byte;
            r_s1_kind  <= e_kind;
            r_s1_trunc <= e_trunc;
            r_s1_last  <= e_last;
        end
    end

    // Output register: hold while stalled, advance from the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_byte  <= r_s1_mem ? r_rd_data : r_s1_byte;
            r_out_kind  <= r_s1_kind;
            r_out_trunc <= r_s1_trunc;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_out_kind       = r_out_kind;
    assign o_name_truncated = r_out_trunc;
    assign o_last_result    = r_out_last;

endmodule
